[rtl/hrlm_pkg.sv]
// Shared constants, command codes and beat/result types for the report
// learn-and-match block. No dependencies.
package hrlm_pkg;

    localparam int PATTERN_BYTES = 8;
    localparam int REPORT_MAX    = 64;

    localparam int IDX_W     = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
    localparam int LEN_W     = $clog2(PATTERN_BYTES + 1);
    localparam int CNT_W     = $clog2(REPORT_MAX + 1);
    localparam int NUM_BANKS = 3;
    localparam int BANK_W    = 2;
    localparam int RAM_DEPTH = NUM_BANKS * PATTERN_BYTES;
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PW    = 2;
    localparam int Q_CW    = 3;

    typedef enum logic [1:0] {
        CMD_BYTE   = 2'd0,
        CMD_ARM    = 2'd1,
        CMD_CANCEL = 2'd2
    } cmd_t;

    typedef struct packed {
        logic              valid;
        cmd_t              cmd;
        logic [7:0]        data;
        logic              last;
        logic [15:0]       handle;
        logic              tgt;
        logic              rel;
        logic              in_pat;
        logic              nz;
        logic [LEN_W-1:0]  len;
    } beat_t;

    typedef struct packed {
        logic [BANK_W-1:0] fwd;
        logic [BANK_W-1:0] back;
        logic [BANK_W-1:0] cap;
    } bank_map_t;

    // packed from MSB: action_valid lands in bit 0
    typedef struct packed {
        logic learned_target;
        logic learned;
        logic action;
        logic action_valid;
    } result_t;

    function automatic logic [RAM_AW-1:0] bank_addr(input logic [BANK_W-1:0] bank,
                                                    input logic [IDX_W-1:0] idx);
        bank_addr = RAM_AW'(bank) * RAM_AW'(PATTERN_BYTES) + RAM_AW'(idx);
    endfunction

endpackage

[rtl/hid_report_learn_and_match.sv]
// Top level of the report learn-and-match block.
// Depends on hrlm_pkg, hrlm_ram, hrlm_front, hrlm_match, hrlm_outq.
//
//  channel | dir | handshake        | payload
//  s_      | in  | s_tvalid/tready  | tdata: data_byte, rpt_handle, learn_target,
//          |     |                  |        require_release; tuser: cmd; tlast
//  m_      | out | m_tvalid/tready  | tdata: action_valid, action, learned,
//          |     |                  |        learned_target
//
// One input beat per cycle while s_tready is high. The last beat of a report
// passes the registered pattern RAM read, then the compare/decide stage, which
// writes its result into the queue. Pattern bytes live in a three-bank RAM;
// capture is a bank swap, so reset needs no clearing pass. s_tready drops only
// while the four-entry result queue could overflow.
module hid_report_learn_and_match import hrlm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [7:0] data_byte, [23:8] rpt_handle,
                                   // [24] learn_target, [25] require_release
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] action_valid, [1] action, [2] learned,
                                   // [3] learned_target
);

    logic              accept;
    bank_map_t         banks_next;
    beat_t             beat;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr_fwd, ram_raddr_back;
    logic [7:0]        ram_wdata, rd_fwd, rd_back;
    logic              push;
    result_t           result;
    logic              pending;

    assign accept  = s_tvalid && s_tready;
    assign pending = beat.valid && beat.cmd == CMD_BYTE && beat.last;

    hrlm_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .cmd             (cmd_t'(s_tuser)),
        .data_byte       (s_tdata[7:0]),
        .last_byte       (s_tlast),
        .rpt_handle      (s_tdata[23:8]),
        .learn_target    (s_tdata[24]),
        .require_release (s_tdata[25]),
        .banks           (banks_next),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_raddr_fwd   (ram_raddr_fwd),
        .ram_raddr_back  (ram_raddr_back),
        .beat            (beat)
    );

    hrlm_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_fwd),
        .raddr_b (ram_raddr_back),
        .rdata_a (rd_fwd),
        .rdata_b (rd_back)
    );

    hrlm_match u_match (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat       (beat),
        .rd_fwd     (rd_fwd),
        .rd_back    (rd_back),
        .banks_next (banks_next),
        .push       (push),
        .result     (result)
    );

    hrlm_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .din      (result),
        .pending  (pending),
        .room     (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[rtl/hrlm_ram.sv]
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module hrlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 24,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[rtl/hrlm_front.sv]
// Input stage: byte counter, non-zero tracking and pattern RAM addressing.
// Depends on hrlm_pkg.
module hrlm_front import hrlm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  cmd_t              cmd,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic [15:0]       rpt_handle,
    input  logic              learn_target,
    input  logic              require_release,
    input  bank_map_t         banks,
    output logic              ram_we,
    output logic [RAM_AW-1:0] ram_waddr,
    output logic [7:0]        ram_wdata,
    output logic [RAM_AW-1:0] ram_raddr_fwd,
    output logic [RAM_AW-1:0] ram_raddr_back,
    output beat_t             beat
);

    logic [CNT_W-1:0] seen_cnt_reg, seen_cnt_next;
    logic             seen_nz_reg, seen_nz_next;
    beat_t            beat_reg, beat_next;

    logic             counted;
    logic             in_pat;
    logic [CNT_W-1:0] cnt_after;
    logic             nz_after;
    logic [IDX_W-1:0] idx;

    always_comb begin
        counted   = seen_cnt_reg < CNT_W'(REPORT_MAX);
        in_pat    = seen_cnt_reg < CNT_W'(PATTERN_BYTES);
        cnt_after = counted ? seen_cnt_reg + CNT_W'(1) : seen_cnt_reg;
        nz_after  = seen_nz_reg | (counted & (data_byte != 8'd0));
        idx       = IDX_W'(seen_cnt_reg);

        seen_cnt_next = seen_cnt_reg;
        seen_nz_next  = seen_nz_reg;
        if (accept && cmd == CMD_BYTE) begin
            if (last_byte) begin
                seen_cnt_next = '0;
                seen_nz_next  = 1'b0;
            end else begin
                seen_cnt_next = cnt_after;
                seen_nz_next  = nz_after;
            end
        end

        beat_next.valid  = accept;
        beat_next.cmd    = cmd;
        beat_next.data   = data_byte;
        beat_next.last   = last_byte;
        beat_next.handle = rpt_handle;
        beat_next.tgt    = learn_target;
        beat_next.rel    = require_release;
        beat_next.in_pat = in_pat;
        beat_next.nz     = nz_after;
        beat_next.len    = (cnt_after < CNT_W'(PATTERN_BYTES)) ? LEN_W'(cnt_after)
                                                               : LEN_W'(PATTERN_BYTES);
    end

    assign ram_we         = accept && cmd == CMD_BYTE && in_pat;
    assign ram_waddr      = bank_addr(banks.cap, idx);
    assign ram_wdata      = data_byte;
    assign ram_raddr_fwd  = bank_addr(banks.fwd, idx);
    assign ram_raddr_back = bank_addr(banks.back, idx);
    assign beat           = beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_cnt_reg <= '0;
            seen_nz_reg  <= 1'b0;
            beat_reg     <= '0;
        end else begin
            seen_cnt_reg <= seen_cnt_next;
            seen_nz_reg  <= seen_nz_next;
            beat_reg     <= beat_next;
        end
    end

endmodule

[rtl/hrlm_match.sv]
// Decision stage: pattern state, learn control, compare against RAM data and
// bank swapping on capture. Depends on hrlm_pkg.
module hrlm_match import hrlm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  beat_t      beat,
    input  logic [7:0] rd_fwd,
    input  logic [7:0] rd_back,
    output bank_map_t  banks_next,
    output logic       push,
    output result_t    result
);

    localparam logic [BANK_W-1:0] BANK_FWD_RST  = BANK_W'(0);
    localparam logic [BANK_W-1:0] BANK_BACK_RST = BANK_W'(1);
    localparam logic [BANK_W-1:0] BANK_CAP_RST  = BANK_W'(2);

    logic             fwd_valid_reg, fwd_valid_next;
    logic [15:0]      fwd_handle_reg, fwd_handle_next;
    logic [LEN_W-1:0] fwd_len_reg, fwd_len_next;
    logic             back_valid_reg, back_valid_next;
    logic [15:0]      back_handle_reg, back_handle_next;
    logic [LEN_W-1:0] back_len_reg, back_len_next;
    logic             fwd_eq_reg, fwd_eq_next;
    logic             back_eq_reg, back_eq_next;
    logic             armed_reg, armed_next;
    logic             for_back_reg, for_back_next;
    logic             await_reg, await_next;
    bank_map_t        banks_reg;

    logic feq, beq, fm, bm;

    always_comb begin
        fwd_valid_next   = fwd_valid_reg;
        fwd_handle_next  = fwd_handle_reg;
        fwd_len_next     = fwd_len_reg;
        back_valid_next  = back_valid_reg;
        back_handle_next = back_handle_reg;
        back_len_next    = back_len_reg;
        fwd_eq_next      = fwd_eq_reg;
        back_eq_next     = back_eq_reg;
        armed_next       = armed_reg;
        for_back_next    = for_back_reg;
        await_next       = await_reg;
        banks_next       = banks_reg;
        push             = 1'b0;
        result           = '0;

        feq = fwd_eq_reg & (!beat.in_pat | (rd_fwd == beat.data));
        beq = back_eq_reg & (!beat.in_pat | (rd_back == beat.data));
        fm  = fwd_valid_reg && fwd_handle_reg == beat.handle
              && fwd_len_reg == beat.len && feq;
        bm  = back_valid_reg && back_handle_reg == beat.handle
              && back_len_reg == beat.len && beq;

        if (beat.valid) begin
            case (beat.cmd)
                CMD_ARM: begin
                    for_back_next = beat.tgt;
                    await_next    = beat.rel;
                    armed_next    = 1'b1;
                end
                CMD_CANCEL: begin
                    armed_next = 1'b0;
                end
                CMD_BYTE: begin
                    if (!beat.last) begin
                        fwd_eq_next  = feq;
                        back_eq_next = beq;
                    end else begin
                        fwd_eq_next  = 1'b1;
                        back_eq_next = 1'b1;
                        if (!beat.nz) begin
                            await_next = 1'b0;
                        end else if (armed_reg) begin
                            if (!await_reg) begin
                                // captured bank becomes the target; old target bank is reused
                                if (for_back_reg) begin
                                    back_valid_next  = 1'b1;
                                    back_handle_next = beat.handle;
                                    back_len_next    = beat.len;
                                    banks_next.back  = banks_reg.cap;
                                    banks_next.cap   = banks_reg.back;
                                end else begin
                                    fwd_valid_next  = 1'b1;
                                    fwd_handle_next = beat.handle;
                                    fwd_len_next    = beat.len;
                                    banks_next.fwd  = banks_reg.cap;
                                    banks_next.cap  = banks_reg.fwd;
                                end
                                push                  = 1'b1;
                                result.learned        = 1'b1;
                                result.learned_target = for_back_reg;
                                armed_next            = 1'b0;
                                await_next            = 1'b1;
                            end
                        end else if (fm || bm) begin
                            push                = 1'b1;
                            result.action_valid = 1'b1;
                            result.action       = !fm;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg   <= 1'b0;
            fwd_handle_reg  <= '0;
            fwd_len_reg     <= '0;
            back_valid_reg  <= 1'b0;
            back_handle_reg <= '0;
            back_len_reg    <= '0;
            fwd_eq_reg      <= 1'b1;
            back_eq_reg     <= 1'b1;
            armed_reg       <= 1'b0;
            for_back_reg    <= 1'b0;
            await_reg       <= 1'b0;
            banks_reg.fwd   <= BANK_FWD_RST;
            banks_reg.back  <= BANK_BACK_RST;
            banks_reg.cap   <= BANK_CAP_RST;
        end else begin
            fwd_valid_reg   <= fwd_valid_next;
            fwd_handle_reg  <= fwd_handle_next;
            fwd_len_reg     <= fwd_len_next;
            back_valid_reg  <= back_valid_next;
            back_handle_reg <= back_handle_next;
            back_len_reg    <= back_len_next;
            fwd_eq_reg      <= fwd_eq_next;
            back_eq_reg     <= back_eq_next;
            armed_reg       <= armed_next;
            for_back_reg    <= for_back_next;
            await_reg       <= await_next;
            banks_reg       <= banks_next;
        end
    end

endmodule

[rtl/hrlm_outq.sv]
// Result queue: small FIFO between the decision stage and the output stream.
// Depends on hrlm_pkg.
module hrlm_outq import hrlm_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t din,
    input  logic    pending,
    output logic    room,
    output logic    m_tvalid,
    input  logic    m_tready,
    output logic [7:0] m_tdata
);

    result_t         q_mem [Q_DEPTH];
    logic [Q_PW-1:0] wptr_reg, rptr_reg;
    logic [Q_CW-1:0] count_reg, count_next;
    logic            pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = {4'd0, q_mem[rptr_reg]};
    // one beat may still produce a result, and the next accepted beat one more
    assign room     = (count_reg + Q_CW'(pending)) <= Q_CW'(Q_DEPTH - 1);

    always_comb begin
        count_next = count_reg + Q_CW'(push) - Q_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + Q_PW'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + Q_PW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

[test/hid_report_learn_and_match_check.sv]
// Checker for hid_report_learn_and_match: watches both stream channels, tracks
// learned patterns and the report in progress, and compares every result beat.
// Depends on hrlm_pkg.
`timescale 1ns / 100ps

module hid_report_learn_and_match_check import hrlm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [7:0] data_byte, [23:8] rpt_handle,
                                   // [24] learn_target, [25] require_release
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [0] action_valid, [1] action, [2] learned,
                                   // [3] learned_target
    output int          pending,
    output int          failures
);

    // index 0: forward pattern, 1: back pattern
    logic             pat_ok[2];
    logic [15:0]      pat_handle[2];
    logic [LEN_W-1:0] pat_len[2];
    logic [7:0]       pat_bytes[2][PATTERN_BYTES];

    logic [CNT_W-1:0] seen;
    logic             seen_nz;
    logic [7:0]       cap[PATTERN_BYTES];
    logic             still_eq[2];
    logic             armed;
    logic             arm_back;
    logic             hold_release;

    result_t          due_outcomes[$];

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ERROR %s: got %0h, want %0h", $time, what, got, want);
        failures++;
    endtask

    task automatic restart_report();
        seen        = '0;
        seen_nz     = 1'b0;
        still_eq[0] = 1'b1;
        still_eq[1] = 1'b1;
    endtask

    task automatic clear_all();
        for (int k = 0; k < 2; k++) begin
            pat_ok[k]     = 1'b0;
            pat_handle[k] = '0;
            pat_len[k]    = '0;
            for (int j = 0; j < PATTERN_BYTES; j++) pat_bytes[k][j] = '0;
        end
        for (int j = 0; j < PATTERN_BYTES; j++) cap[j] = '0;
        armed        = 1'b0;
        arm_back     = 1'b0;
        hold_release = 1'b0;
        restart_report();
        due_outcomes.delete();
    endtask

    task automatic track_report_beat(input logic [1:0] cmd, input logic [7:0] b,
                                     input logic fin, input logic [15:0] h,
                                     input logic tgt, input logic rel);
        int               n;
        int               k;
        logic [LEN_W-1:0] len;
        logic             hit[2];
        result_t          r;
        r = '0;
        case (cmd)
            CMD_ARM: begin
                arm_back     = tgt;
                hold_release = rel;
                armed        = 1'b1;
            end
            CMD_CANCEL: armed = 1'b0;
            CMD_BYTE: begin
                n = int'(seen);
                if (n < REPORT_MAX) begin
                    if (n < PATTERN_BYTES) begin
                        cap[n] = b;
                        for (k = 0; k < 2; k++)
                            if (pat_bytes[k][n] != b) still_eq[k] = 1'b0;
                    end
                    if (b != 8'd0) seen_nz = 1'b1;
                    seen = seen + CNT_W'(1);
                end
                if (fin) begin
                    n   = int'(seen);
                    len = (n < PATTERN_BYTES) ? LEN_W'(n) : LEN_W'(PATTERN_BYTES);
                    if (!seen_nz) begin
                        hold_release = 1'b0;
                    end else if (armed) begin
                        if (!hold_release) begin
                            k             = int'(arm_back);
                            pat_ok[k]     = 1'b1;
                            pat_handle[k] = h;
                            pat_len[k]    = len;
                            for (int j = 0; j < PATTERN_BYTES; j++) pat_bytes[k][j] = cap[j];
                            r.learned        = 1'b1;
                            r.learned_target = arm_back;
                            due_outcomes.push_back(r);
                            armed        = 1'b0;
                            hold_release = 1'b1;
                        end
                    end else begin
                        for (k = 0; k < 2; k++)
                            hit[k] = pat_ok[k] && pat_handle[k] == h && pat_len[k] == len
                                     && still_eq[k];
                        if (hit[0] || hit[1]) begin
                            r.action_valid = 1'b1;
                            r.action       = !hit[0];
                            due_outcomes.push_back(r);
                        end
                    end
                    restart_report();
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        result_t r;
        if (!aresetn) begin
            clear_all();
            failures = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_outcomes.size() == 0) begin
                    report_mismatch("result beat with none expected", m_tdata, 8'd0);
                end else begin
                    r = due_outcomes.pop_front();
                    if (m_tdata[0] !== r.action_valid)
                        report_mismatch("action_valid", {7'd0, m_tdata[0]},
                                        {7'd0, r.action_valid});
                    if (m_tdata[1] !== r.action)
                        report_mismatch("action", {7'd0, m_tdata[1]}, {7'd0, r.action});
                    if (m_tdata[2] !== r.learned)
                        report_mismatch("learned", {7'd0, m_tdata[2]}, {7'd0, r.learned});
                    if (m_tdata[3] !== r.learned_target)
                        report_mismatch("learned_target", {7'd0, m_tdata[3]},
                                        {7'd0, r.learned_target});
                end
            end
            if (s_tvalid && s_tready)
                track_report_beat(s_tuser, s_tdata[7:0], s_tlast, s_tdata[23:8],
                                  s_tdata[24], s_tdata[25]);
        end
        pending <= due_outcomes.size();
    end

endmodule

[test/hid_report_learn_and_match_test.sv]
// Testbench top for hid_report_learn_and_match: clock, reset, report and command
// stimulus, receiver stalls, watchdog and verdict.
// Depends on hrlm_pkg, the block's RTL and hid_report_learn_and_match_check.
`timescale 1ns / 100ps

module hid_report_learn_and_match_test;
    import hrlm_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int HIST       = 8;
    localparam int HIST_BYTES = 80;
    localparam int HOLD_LEN   = 300;
    localparam int IDLE_LIMIT = 3000;
    localparam int TAIL_WAIT  = 20;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    int pending;
    int failures;
    int beats    = 0;
    bit gaps_on  = 1'b1;
    bit hold_ask = 1'b0;

    logic [7:0]  rpt[$];
    logic [7:0]  hist_b[HIST][HIST_BYTES];
    int          hist_len[HIST];
    logic [15:0] hist_h[HIST];
    int          hist_cnt = 0;
    int          hist_wr  = 0;

    hid_report_learn_and_match DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hid_report_learn_and_match_check match_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .pending  (pending),
        .failures (failures)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [15:0] rnd16();
        return 16'($urandom_range(65535));
    endfunction

    function automatic bit coin(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 4)  return $urandom_range(72, 60);
        if (r < 15) return $urandom_range(20, 9);
        return $urandom_range(8, 1);
    endfunction

    function automatic logic [15:0] pick_handle();
        if (coin(30)) return 16'h0000;
        if (coin(12)) return 16'hFFFF;
        return rnd16();
    endfunction

    // one input beat, held until accepted
    task automatic put(input logic [1:0] cmd, input logic [7:0] d, input logic fin,
                       input logic [15:0] h, input logic tgt, input logic rel);
        @(negedge aclk);
        if (gaps_on && coin(11)) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, rel, tgt, h, d};
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats++;
    endtask

    task automatic side_cmd(input logic [1:0] cmd);
        put(cmd, rnd8(), 1'($urandom_range(1)), rnd16(), 1'($urandom_range(1)),
            1'($urandom_range(1)));
    endtask

    task automatic random_side_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 45)      side_cmd(CMD_ARM);
        else if (r < 80) side_cmd(CMD_CANCEL);
        else             side_cmd(CMD_UNUSED);
    endtask

    task automatic send_report(input logic [15:0] h, input bit mix);
        int n;
        n = rpt.size();
        for (int i = 0; i < n; i++) begin
            if (mix && i < n - 1 && coin(3)) random_side_cmd();
            put(CMD_BYTE, rpt[i], i == n - 1, (i == n - 1) ? h : rnd16(),
                1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        for (int i = 0; i < n && i < HIST_BYTES; i++) hist_b[hist_wr][i] = rpt[i];
        hist_len[hist_wr] = n;
        hist_h[hist_wr]   = h;
        hist_wr = (hist_wr + 1) % HIST;
        if (hist_cnt < HIST) hist_cnt++;
    endtask

    task automatic random_until(input int goal);
        int          r;
        int          n;
        int          j;
        int          k;
        logic [15:0] h;
        while (beats < goal) begin
            r = $urandom_range(99);
            rpt.delete();
            if (r < 7) begin
                side_cmd(CMD_ARM);
            end else if (r < 10) begin
                side_cmd(CMD_CANCEL);
            end else if (r < 12) begin
                side_cmd(CMD_UNUSED);
            end else if (r < 22) begin
                // zero report; bytes past the report limit are not seen
                n = pick_len();
                for (int i = 0; i < n; i++) rpt.push_back(i < REPORT_MAX ? 8'd0 : rnd8());
                send_report(pick_handle(), 1'b1);
            end else if (r < 67 && hist_cnt > 0) begin
                j = $urandom_range(hist_cnt - 1);
                for (int i = 0; i < hist_len[j]; i++) rpt.push_back(hist_b[j][i]);
                h = hist_h[j];
                if (rpt.size() >= PATTERN_BYTES && coin(30)) begin
                    n = $urandom_range(72, PATTERN_BYTES);
                    while (rpt.size() > n) void'(rpt.pop_back());
                    while (rpt.size() < n) rpt.push_back(rnd8());
                end
                if (coin(15)) begin
                    n = (rpt.size() < PATTERN_BYTES) ? rpt.size() : PATTERN_BYTES;
                    k = $urandom_range(n - 1);
                    rpt[k] = rpt[k] ^ (8'd1 << $urandom_range(7));
                end else if (coin(5)) begin
                    h = h ^ (16'd1 << $urandom_range(15));
                end
                send_report(h, 1'b1);
            end else begin
                n = pick_len();
                for (int i = 0; i < n; i++) rpt.push_back(coin(25) ? 8'd0 : rnd8());
                send_report(pick_handle(), 1'b1);
            end
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_ask) begin
                hold_ask  = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !gaps_on || !coin(16);
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int n;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed
        rpt = '{8'h00};
        send_report(16'h0000, 1'b0);                 // all-zero, nothing learned
        rpt = '{8'hFF};
        send_report(16'hFFFF, 1'b0);                 // no pattern yet
        put(CMD_ARM, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0);
        rpt = '{8'h01, 8'h80};
        send_report(16'h1234, 1'b0);                 // learn forward
        send_report(16'h1234, 1'b0);                 // forward match
        put(CMD_ARM, 8'hFF, 1'b1, 16'hFFFF, 1'b1, 1'b1);
        rpt = '{8'h05};
        send_report(16'h0001, 1'b0);                 // dropped, release pending
        rpt = '{8'h00, 8'h00};
        send_report(16'hABCD, 1'b0);                 // release
        rpt = '{8'h05};
        send_report(16'h0000, 1'b0);                 // learn back
        send_report(16'h0000, 1'b0);                 // back match
        rpt = '{8'h01, 8'h80};
        send_report(16'h1235, 1'b0);                 // handle differs
        put(CMD_UNUSED, 8'hA5, 1'b1, 16'h5A5A, 1'b1, 1'b1);
        put(CMD_ARM, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0);
        put(CMD_CANCEL, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0);
        rpt = '{8'h05};
        send_report(16'h0000, 1'b0);                 // matches back after cancel

        random_until(650);

        // long receiver hold-off with a burst of matching reports
        hold_ask = 1'b1;
        put(CMD_ARM, rnd8(), 1'b0, rnd16(), 1'b0, 1'b0);
        n = $urandom_range(3, 1);
        rpt.delete();
        for (int i = 0; i < n; i++) rpt.push_back(8'(1 + $urandom_range(254)));
        repeat (11) send_report(16'h00A5, 1'b0);

        drain();
        gaps_on = 1'b0;
        random_until(1050);
        gaps_on = 1'b1;
        random_until(1550);

        drain();
        repeat (TAIL_WAIT) @(posedge aclk);
        if (failures == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
